@@ hdl/rrs_pkg.sv @@
// Shared types, constants and helper functions of the three-level round-robin scheduler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rrs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_LEVELS  = 3;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    localparam logic FUNC_ADD     = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_level;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_PRIO = 3'd2,
        ST_REQUEUED = 3'd3,
        ST_FINISHED = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    typedef struct packed {
        logic        func;
        logic [7:0]  task_id;
        logic [15:0] task_time;
        logic [1:0]  priority_req;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  served_task_id;
        logic [7:0]  run_time;
        logic [15:0] remaining_time;
        logic [1:0]  served_level;
    } t_result;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] task_time;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_level push_lvl;
        logic   pop;
    } t_ptr_req;

    typedef struct packed {
        logic   any_pending;
        t_level pop_lvl;
        t_addr  head_addr;
        logic   push_full;
        t_addr  tail_addr;
    } t_ptr_stat;

    function automatic t_ptr ptr_inc(input t_ptr p);
        ptr_inc = (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_addr slot_addr(input t_level lvl, input t_ptr p);
        case (lvl)
            2'd0:    slot_addr = t_addr'(p);
            2'd1:    slot_addr = t_addr'(QUEUE_DEPTH) + t_addr'(p);
            default: slot_addr = t_addr'(2 * QUEUE_DEPTH) + t_addr'(p);
        endcase
    endfunction

endpackage

@@ hdl/rrs_mem.sv @@
// Task entry store: one array holding the FIFO slots of all three levels.
// One write port and one read port with registered read data; uses rrs_pkg.
module rrs_mem (
    input  logic            i_clk,
    input  logic            i_we,
    input  rrs_pkg::t_addr  i_waddr,
    input  rrs_pkg::t_entry i_wdata,
    input  rrs_pkg::t_addr  i_raddr,
    output rrs_pkg::t_entry o_rdata
);

    rrs_pkg::t_entry r_mem [rrs_pkg::NUM_LEVELS * rrs_pkg::QUEUE_DEPTH];
    rrs_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rrs_ptrs.sv @@
// Head pointers, tail pointers and fill counts of the three FIFO levels.
// Picks the highest non-empty level for a pop; uses rrs_pkg.
module rrs_ptrs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrs_pkg::t_ptr_req  i_req,
    output rrs_pkg::t_ptr_stat o_stat
);

    rrs_pkg::t_ptr r_head [rrs_pkg::NUM_LEVELS];
    rrs_pkg::t_ptr r_tail [rrs_pkg::NUM_LEVELS];
    rrs_pkg::t_cnt r_cnt  [rrs_pkg::NUM_LEVELS];
    rrs_pkg::t_ptr n_head [rrs_pkg::NUM_LEVELS];
    rrs_pkg::t_ptr n_tail [rrs_pkg::NUM_LEVELS];
    rrs_pkg::t_cnt n_cnt  [rrs_pkg::NUM_LEVELS];

    rrs_pkg::t_level pop_lvl;
    logic            any_pending;
    rrs_pkg::t_ptr   head_sel;
    rrs_pkg::t_ptr   tail_sel;
    logic            full_sel;

    always_comb begin
        any_pending = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);
        if (r_cnt[2] != '0) begin
            pop_lvl = 2'd2;
        end else if (r_cnt[1] != '0) begin
            pop_lvl = 2'd1;
        end else begin
            pop_lvl = 2'd0;
        end
        case (pop_lvl)
            2'd2:    head_sel = r_head[2];
            2'd1:    head_sel = r_head[1];
            default: head_sel = r_head[0];
        endcase
        case (i_req.push_lvl)
            2'd0: begin
                tail_sel = r_tail[0];
                full_sel = (r_cnt[0] == rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH));
            end
            2'd1: begin
                tail_sel = r_tail[1];
                full_sel = (r_cnt[1] == rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH));
            end
            2'd2: begin
                tail_sel = r_tail[2];
                full_sel = (r_cnt[2] == rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH));
            end
            default: begin
                tail_sel = r_tail[0];
                full_sel = 1'b1;
            end
        endcase
    end

    assign o_stat.any_pending = any_pending;
    assign o_stat.pop_lvl     = pop_lvl;
    assign o_stat.head_addr   = rrs_pkg::slot_addr(pop_lvl, head_sel);
    assign o_stat.push_full   = full_sel;
    assign o_stat.tail_addr   = rrs_pkg::slot_addr(i_req.push_lvl, tail_sel);

    always_comb begin
        logic pop_hit;
        logic push_hit;
        for (int l = 0; l < rrs_pkg::NUM_LEVELS; l++) begin
            pop_hit  = i_req.pop && any_pending && (pop_lvl == rrs_pkg::t_level'(l));
            push_hit = i_req.push && (i_req.push_lvl == rrs_pkg::t_level'(l));
            n_head[l] = pop_hit ? rrs_pkg::ptr_inc(r_head[l]) : r_head[l];
            n_tail[l] = push_hit ? rrs_pkg::ptr_inc(r_tail[l]) : r_tail[l];
            case ({push_hit, pop_hit})
                2'b10:   n_cnt[l] = r_cnt[l] + rrs_pkg::t_cnt'(1);
                2'b01:   n_cnt[l] = r_cnt[l] - rrs_pkg::t_cnt'(1);
                default: n_cnt[l] = r_cnt[l];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < rrs_pkg::NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else begin
            for (int l = 0; l < rrs_pkg::NUM_LEVELS; l++) begin
                r_head[l] <= n_head[l];
                r_tail[l] <= n_tail[l];
                r_cnt[l]  <= n_cnt[l];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH)) &&
        (r_cnt[1] <= rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH)) &&
        (r_cnt[2] <= rrs_pkg::t_cnt'(rrs_pkg::QUEUE_DEPTH)))
        else $error("fill count above queue depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> !o_stat.push_full)
        else $error("push into a full level");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.push && i_req.pop))
        else $error("push and pop in the same cycle");

endmodule

@@ hdl/three_level_round_robin_scheduler_top.sv @@
// An add item gives its result in the cycle after acceptance and leaves busy low.
// A process item with a pending task gives its result through the registered read of the
// entry store and then the result register, and holds busy high for one cycle.
// Add items are taken one per cycle while busy is low; no new item is taken while busy is high.
// Synchronous reset empties all three levels and sets the quantum to 2; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle under o_strobe.
module three_level_round_robin_scheduler_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rrs_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    output logic             o_strobe,
    output rrs_pkg::t_result o_result
);

    logic             r_busy;
    logic             n_busy;
    rrs_pkg::t_level  r_lvl;
    logic [7:0]       r_quantum;
    logic             r_strobe;
    logic             n_strobe;
    rrs_pkg::t_result r_result;
    rrs_pkg::t_result n_result;

    rrs_pkg::t_ptr_req  req;
    rrs_pkg::t_ptr_stat stat;
    rrs_pkg::t_entry    wdata;
    rrs_pkg::t_entry    rdata;

    logic            accept;
    logic            is_add;
    logic            bad_prio;
    rrs_pkg::t_level add_lvl;
    logic [7:0]      run;
    logic [15:0]     rem_out;
    logic            requeue;

    assign accept   = start && !r_busy;
    assign is_add   = (i_item.func == rrs_pkg::FUNC_ADD);
    assign bad_prio = (i_item.priority_req == 2'd0);
    assign add_lvl  = i_item.priority_req - 2'd1;

    assign run     = (rdata.task_time > {8'd0, r_quantum}) ? r_quantum : rdata.task_time[7:0];
    assign rem_out = rdata.task_time - {8'd0, run};
    assign requeue = (rem_out != 16'd0);

    always_comb begin
        req.push     = (accept && is_add && !bad_prio && !stat.push_full) ||
                       (r_busy && requeue);
        req.push_lvl = r_busy ? r_lvl : add_lvl;
        req.pop      = accept && (i_item.func == rrs_pkg::FUNC_PROCESS);
        if (r_busy) begin
            wdata.task_id   = rdata.task_id;
            wdata.task_time = rem_out;
        end else begin
            wdata.task_id   = i_item.task_id;
            wdata.task_time = i_item.task_time;
        end
    end

    rrs_ptrs u_ptrs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_stat  (stat)
    );

    rrs_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (req.push),
        .i_waddr (stat.tail_addr),
        .i_wdata (wdata),
        .i_raddr (stat.head_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_strobe = 1'b0;
        n_result = r_result;
        n_busy   = accept && !is_add && stat.any_pending;
        if (r_busy) begin
            n_strobe                = 1'b1;
            n_result.status         = requeue ? rrs_pkg::ST_REQUEUED : rrs_pkg::ST_FINISHED;
            n_result.served_task_id = rdata.task_id;
            n_result.run_time       = run;
            n_result.remaining_time = rem_out;
            n_result.served_level   = r_lvl + 2'd1;
        end else if (accept && (is_add || !stat.any_pending)) begin
            n_strobe                = 1'b1;
            n_result.served_task_id = 8'd0;
            n_result.run_time       = 8'd0;
            n_result.remaining_time = 16'd0;
            n_result.served_level   = 2'd0;
            if (!is_add) begin
                n_result.status = rrs_pkg::ST_NONE;
            end else if (bad_prio) begin
                n_result.status = rrs_pkg::ST_BAD_PRIO;
            end else if (stat.push_full) begin
                n_result.status = rrs_pkg::ST_FULL;
            end else begin
                n_result.status = rrs_pkg::ST_ADDED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_strobe  <= 1'b0;
            r_quantum <= rrs_pkg::QUANTUM_RESET;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_lvl <= stat.pop_lvl;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one cycle");

    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_add) |=> o_strobe)
        else $error("add item gave no result");

    a_process_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (o_strobe && o_result.served_level != 2'd0))
        else $error("served task gave no result");

    a_push_when_requeue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && requeue) |-> req.push)
        else $error("requeue lost");

endmodule
